FILE: rtl/vsp_pkg.sv
// Package for the vertex screen projection unit.
// Holds default formats, field widths and register indexes. No dependencies.
package vsp_pkg;
  localparam int unsigned DefCoordFracBits = 16;
  localparam int unsigned DefCoefFracBits  = 12;
  localparam int unsigned CoordW   = 32;
  localparam int unsigned CoefW    = 16;
  localparam int unsigned RowW     = 64;
  localparam int unsigned DimW     = 13;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned QuotW    = 32;

  localparam logic [CfgIdxW-1:0] RegRow0   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegRow1   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRow2   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRow3   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegWidth  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegHeight = 3'd5;

  localparam logic [DimW-1:0] ResetWidth  = 13'd640;
  localparam logic [DimW-1:0] ResetHeight = 13'd480;
endpackage

FILE: rtl/vertex_screen_projection_unit.sv
// Vertex screen projection unit: 4x4 matrix transform, perspective divide and
// viewport map, as one deep pipeline. Depends on vsp_pkg.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+--------------------------------
//  vertex  | in        | in_valid_i / in_ready_o  | vertex_x/y/z/w_i (Q16.16)
//  screen  | out       | out_valid_o/out_ready_i  | screen_x_o, screen_y_o, w_zero_o
//  config  | in        | cfg_valid_i/cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One word per clock in and out while the output is not stalled. Stages: multiply,
// row sum, numerator prep, viewport multiply, overflow check, 32 quotient-bit stages
// (one restoring divide step each, both axes in parallel), then saturation.
// Every stage carries a valid bit and holds when the stage after it is full
// and stalled, so bubbles fill up behind a stalled output and nothing is lost.
// Reset clears the valid bits and loads the identity matrix and a 640x480
// viewport. Config writes are always taken.
module vertex_screen_projection_unit #(
  parameter int unsigned COORD_FRAC_BITS = vsp_pkg::DefCoordFracBits,
  parameter int unsigned COEF_FRAC_BITS  = vsp_pkg::DefCoefFracBits
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [vsp_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [vsp_pkg::RowW-1:0]            cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [vsp_pkg::CoordW-1:0]   vertex_x_i,
  input  logic signed [vsp_pkg::CoordW-1:0]   vertex_y_i,
  input  logic signed [vsp_pkg::CoordW-1:0]   vertex_z_i,
  input  logic signed [vsp_pkg::CoordW-1:0]   vertex_w_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [vsp_pkg::CoordW-1:0]   screen_x_o,
  output logic signed [vsp_pkg::CoordW-1:0]   screen_y_o,
  output logic                                w_zero_o
);
  import vsp_pkg::*;

  localparam int unsigned ProdW = CoordW + CoefW;          // one product
  localparam int unsigned SumW  = ProdW + 2;               // sum of four
  localparam int unsigned ClipW = SumW - COEF_FRAC_BITS;   // clip coordinate
  localparam int unsigned NumW  = ClipW + 1;               // |n|, 2|cw|, remainder
  localparam int unsigned MulW  = NumW + DimW;             // |n| * dim
  localparam int unsigned NW    = MulW + COORD_FRAC_BITS;  // scaled dividend
  localparam int unsigned HiW   = NW - QuotW;
  localparam int unsigned CmpW  = (HiW > NumW) ? HiW : NumW;
  localparam int unsigned NDiv  = QuotW;
  localparam int unsigned NS    = 4 + NDiv + 2;            // valid bits

  typedef struct packed {
    logic [NumW-1:0]  r;
    logic [QuotW-1:0] lo;
    logic [QuotW-1:0] q;
    logic             ovf;
    logic             neg;
  } lane_t;

  typedef struct packed {
    lane_t           x;
    lane_t           y;
    logic [NumW-1:0] ud;
    logic            wz;
  } div_t;

  // config registers
  logic [RowW-1:0] row_q [4];
  logic [DimW-1:0] width_q, height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 4; r++) begin
        row_q[r] <= RowW'(1) << (COEF_FRAC_BITS + CoefW * r);
      end
      width_q  <= ResetWidth;
      height_q <= ResetHeight;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegRow0:   row_q[0] <= cfg_data_i;
        RegRow1:   row_q[1] <= cfg_data_i;
        RegRow2:   row_q[2] <= cfg_data_i;
        RegRow3:   row_q[3] <= cfg_data_i;
        RegWidth:  width_q  <= cfg_data_i[DimW-1:0];
        RegHeight: height_q <= cfg_data_i[DimW-1:0];
        default: ;
      endcase
    end
  end

  // stall control: a stage moves when it is empty or the next one moves
  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // stage 1: the twelve products (rows 0, 1 and 3; z row is unused)
  logic signed [CoordW-1:0] vtx [4];
  logic signed [ProdW-1:0]  p_q [3][4];

  assign vtx[0] = vertex_x_i;
  assign vtx[1] = vertex_y_i;
  assign vtx[2] = vertex_z_i;
  assign vtx[3] = vertex_w_i;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int j = 0; j < 4; j++) begin
        p_q[0][j] <= ProdW'($signed(row_q[0][CoefW*j +: CoefW])) * ProdW'(vtx[j]);
        p_q[1][j] <= ProdW'($signed(row_q[1][CoefW*j +: CoefW])) * ProdW'(vtx[j]);
        p_q[2][j] <= ProdW'($signed(row_q[3][CoefW*j +: CoefW])) * ProdW'(vtx[j]);
      end
    end
  end

  // stage 2: row sums, floor shift to clip coordinates
  logic signed [SumW-1:0]  sum_d [3];
  logic signed [ClipW-1:0] clip_q [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum_d[r] = SumW'(p_q[r][0]) + SumW'(p_q[r][1]) + SumW'(p_q[r][2])
               + SumW'(p_q[r][3]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int r = 0; r < 3; r++) begin
        clip_q[r] <= ClipW'(sum_d[r] >>> COEF_FRAC_BITS);
      end
    end
  end

  // stage 3: numerators, signs and divisor 2|cw|
  logic signed [NumW-1:0] nx_d, ny_d, cwe_d;
  logic [NumW-1:0]  absx_q, absy_q, ud3_q;
  logic [ClipW-1:0] absw_d;
  logic             negx_q, negy_q, wz3_q;

  always_comb begin
    cwe_d  = NumW'(clip_q[2]);
    nx_d   = NumW'(clip_q[0]) + cwe_d;
    ny_d   = cwe_d - NumW'(clip_q[1]);
    absw_d = clip_q[2][ClipW-1] ? ClipW'(-clip_q[2]) : ClipW'(clip_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      absx_q <= nx_d[NumW-1] ? NumW'(-nx_d) : NumW'(nx_d);
      absy_q <= ny_d[NumW-1] ? NumW'(-ny_d) : NumW'(ny_d);
      negx_q <= nx_d[NumW-1] ^ clip_q[2][ClipW-1];
      negy_q <= ny_d[NumW-1] ^ clip_q[2][ClipW-1];
      ud3_q  <= {absw_d, 1'b0};
      wz3_q  <= (clip_q[2] == '0);
    end
  end

  // stage 4: scale by viewport size
  logic [MulW-1:0] mx_q, my_q;
  logic [NumW-1:0] ud4_q;
  logic            negx4_q, negy4_q, wz4_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      mx_q    <= MulW'(absx_q) * MulW'(width_q);
      my_q    <= MulW'(absy_q) * MulW'(height_q);
      ud4_q   <= ud3_q;
      negx4_q <= negx_q;
      negy4_q <= negy_q;
      wz4_q   <= wz3_q;
    end
  end

  // stage 5: split scaled dividend, catch quotients of 2^32 and up
  function automatic lane_t lane_init(logic [MulW-1:0] m, logic [NumW-1:0] ud,
                                      logic neg);
    logic [NW-1:0]  n;
    logic [CmpW-1:0] hi;
    lane_t l;
    n      = {m, {COORD_FRAC_BITS{1'b0}}};
    hi     = CmpW'(n[NW-1:QuotW]);
    l.ovf  = hi >= CmpW'(ud);
    l.r    = l.ovf ? '0 : NumW'(hi);
    l.lo   = n[QuotW-1:0];
    l.q    = '0;
    l.neg  = neg;
    return l;
  endfunction

  // one restoring divide step
  function automatic lane_t lane_step(lane_t l, logic [NumW-1:0] ud);
    logic [NumW:0] t;
    logic          ge;
    lane_t o;
    t      = {l.r, l.lo[QuotW-1]};
    ge     = t >= {1'b0, ud};
    o      = l;
    o.r    = ge ? NumW'(t - {1'b0, ud}) : NumW'(t);
    o.q    = {l.q[QuotW-2:0], ge};
    o.lo   = {l.lo[QuotW-2:0], 1'b0};
    return o;
  endfunction

  div_t dv_q [NDiv+1];

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      dv_q[0].x  <= lane_init(mx_q, ud4_q, negx4_q);
      dv_q[0].y  <= lane_init(my_q, ud4_q, negy4_q);
      dv_q[0].ud <= ud4_q;
      dv_q[0].wz <= wz4_q;
    end
  end

  for (genvar g = 1; g <= NDiv; g++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (en[4+g]) begin
        dv_q[g].x  <= lane_step(dv_q[g-1].x, dv_q[g-1].ud);
        dv_q[g].y  <= lane_step(dv_q[g-1].y, dv_q[g-1].ud);
        dv_q[g].ud <= dv_q[g-1].ud;
        dv_q[g].wz <= dv_q[g-1].wz;
      end
    end
  end

  // last stage: clamp magnitude, apply sign, zero for w = 0
  function automatic logic [QuotW-1:0] lane_out(lane_t l, logic wz);
    logic [QuotW-1:0] lim;
    logic [QuotW-1:0] mag;
    logic             sat;
    lim = l.neg ? {1'b1, {(QuotW-1){1'b0}}} : {1'b0, {(QuotW-1){1'b1}}};
    sat = l.ovf || (l.q > lim);
    mag = sat ? lim : l.q;
    if (wz) return '0;
    return l.neg ? QuotW'(-mag) : mag;
  endfunction

  logic [QuotW-1:0] sx_q, sy_q;
  logic             wz_q;

  always_ff @(posedge clk_i) begin
    if (en[NS-1]) begin
      sx_q <= lane_out(dv_q[NDiv].x, dv_q[NDiv].wz);
      sy_q <= lane_out(dv_q[NDiv].y, dv_q[NDiv].wz);
      wz_q <= dv_q[NDiv].wz;
    end
  end

  assign out_valid_o = v_q[NS-1];
  assign screen_x_o  = $signed(sx_q);
  assign screen_y_o  = $signed(sy_q);
  assign w_zero_o    = wz_q;
endmodule

FILE: tb/sv/tb.sv
// Testbench for vertex_screen_projection_unit: matrix transform, perspective
// divide and viewport map checked word by word. Depends on vsp_pkg and the RTL.
module tb;
  import vsp_pkg::*;

  localparam int unsigned Latency   = 38;
  localparam int unsigned WatchLimit = 20000;

  // idle profiles
  typedef enum logic [1:0] {IdleNone, IdleSend, IdleRecv, IdleBoth} idle_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [RowW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [CoordW-1:0] vertex_x_i = '0, vertex_y_i = '0, vertex_z_i = '0, vertex_w_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [CoordW-1:0] screen_x_o, screen_y_o;
  logic w_zero_o;

  typedef struct packed {
    logic signed [CoordW-1:0] sx;
    logic signed [CoordW-1:0] sy;
    logic wz;
  } screen_t;

  vertex_screen_projection_unit dut (.*);

  always #5 clk_i = ~clk_i;

  // shadow copy of the register file
  logic [RowW-1:0] mat_rows [4];
  logic [DimW-1:0] view_w, view_h;

  screen_t pending_screens[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  idle_mode_e idle_mode = IdleNone;
  bit hold_off = 1'b0;
  bit timed_out = 1'b0;

  function automatic logic signed [39:0] row_dot(logic [RowW-1:0] row,
                                                 logic signed [CoordW-1:0] v [4]);
    logic signed [63:0] acc;
    acc = 0;
    for (int j = 0; j < 4; j++)
      acc += 64'(signed'(row[16*j +: 16])) * 64'(v[j]);
    return 40'(acc >>> DefCoefFracBits);  // arithmetic shift floors
  endfunction

  // (num * dim * 2^16) / (2 * den), truncated toward zero, then saturated
  function automatic logic [CoordW-1:0] viewport_map(logic signed [40:0] num,
                                                     logic signed [39:0] den,
                                                     logic [DimW-1:0] dim);
    logic [127:0] un, ud, q;
    logic neg;
    logic [127:0] lim;
    neg = (num < 0) != (den < 0);
    un = num < 0 ? 128'(-num) : 128'(num);
    ud = den < 0 ? 128'(-41'(den)) : 128'(den);
    q = ((un * dim) << DefCoordFracBits) / (ud * 2);
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    if (q > lim) q = lim;
    return neg ? CoordW'(-q) : CoordW'(q);
  endfunction

  function automatic screen_t project_vertex(logic signed [CoordW-1:0] v [4]);
    logic signed [39:0] cx, cy, cw;
    screen_t s;
    cx = row_dot(mat_rows[0], v);
    cy = row_dot(mat_rows[1], v);
    cw = row_dot(mat_rows[3], v);
    if (cw == 0) begin
      s = '{sx: '0, sy: '0, wz: 1'b1};
    end else begin
      s.sx = viewport_map(41'(cx) + 41'(cw), cw, view_w);
      s.sy = viewport_map(41'(cw) - 41'(cy), cw, view_h);
      s.wz = 1'b0;
    end
    return s;
  endfunction

  // one register write, with valid dropped again before the task returns
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [RowW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegRow0, RegRow1, RegRow2, RegRow3: mat_rows[idx[1:0]] = data;
      RegWidth:  view_w = data[DimW-1:0];
      RegHeight: view_h = data[DimW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // one vertex word; the expectation is queued at the accepting edge.
  // valid stays up after the accept so words can follow back to back
  task automatic send_vertex(logic signed [CoordW-1:0] x, y, z, w);
    logic signed [CoordW-1:0] v [4];
    v = '{x, y, z, w};
    while ((idle_mode == IdleSend && $urandom_range(99) < 62) ||
           (idle_mode == IdleBoth && $urandom_range(99) < 7)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    vertex_x_i <= x; vertex_y_i <= y; vertex_z_i <= z; vertex_w_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    pending_screens.push_back(project_vertex(v));
  endtask

  task automatic drain_wait();
    in_valid_i <= 1'b0;
    while (pending_screens.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  function automatic logic [CoordW-1:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'h8000_0000 + $urandom_range(3);
      2: return 32'h7fff_ffff - $urandom_range(3);
      default: return CoordW'(signed'($urandom_range(20 << 16)) - (10 << 16));
    endcase
  endfunction

  // Q4.12 coefficient, mostly moderate, sometimes full range
  function automatic logic [15:0] rand_coef();
    return $urandom_range(3) == 0 ? 16'($urandom) :
           16'(signed'($urandom_range(8192)) - 4096);
  endfunction

  function automatic logic [RowW-1:0] rand_row();
    return {rand_coef(), rand_coef(), rand_coef(), rand_coef()};
  endfunction

  task automatic send_random(int unsigned n);
    for (int i = 0; i < n; i++)
      send_vertex(rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endtask

  // receiver side: random stalls plus an optional long hold-off
  always @(posedge clk_i) begin
    if (hold_off)
      out_ready_i <= 1'b0;
    else if (idle_mode == IdleRecv)
      out_ready_i <= $urandom_range(99) >= 62;
    else if (idle_mode == IdleBoth)
      out_ready_i <= $urandom_range(99) >= 7;
    else
      out_ready_i <= rst_ni;
  end

  // result checker
  always @(posedge clk_i) begin
    screen_t exp_s;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_screens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected screen word %h %h %b",
                                       screen_x_o, screen_y_o, w_zero_o);
      end else begin
        exp_s = pending_screens.pop_front();
        if (exp_s.sx !== screen_x_o || exp_s.sy !== screen_y_o || exp_s.wz !== w_zero_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp x=%h y=%h wz=%b got x=%h y=%h wz=%b",
                     exp_s.sx, exp_s.sy, exp_s.wz, screen_x_o, screen_y_o, w_zero_o);
        end
      end
    end
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || hold_off)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    logic signed [CoordW-1:0] one;
    one = 32'sh0001_0000;
    send_vertex(0, 0, 0, one);
    send_vertex(one, one, one, one);
    send_vertex(-one, -one, 0, one);
    send_vertex(0, 0, 0, 0);                         // zero clip w
    send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1);   // saturation
    send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, -1);
    send_vertex(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_vertex(one, 0, 0, -one);                    // negative w
    send_vertex(0, 0, 0, 32'h8000_0000);
    send_vertex(0, 0, 0, 32'h7fff_ffff);
    send_vertex(0, 0, 0, 32'h0000_0fff);             // tiny w
    drain_wait();
    // out-of-list index is ignored
    write_reg(3'd6, '1);
    write_reg(3'd7, '1);
    // zero viewport and maximum 13-bit viewport
    write_reg(RegWidth, '0);
    write_reg(RegHeight, RowW'(13'h1fff));
    send_vertex(one, -one, 0, one);
    send_vertex(32'h7fff_ffff, 0, 0, one);
    drain_wait();
    // all-ones and extreme coefficients, z enters through row 3
    write_reg(RegRow0, {4{16'h8000}});
    write_reg(RegRow1, {4{16'h7fff}});
    write_reg(RegRow2, '1);
    write_reg(RegRow3, 64'h1000_1000_8000_7fff);
    write_reg(RegWidth, RowW'(4096));
    write_reg(RegHeight, RowW'(1));
    send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vertex(one, 0, one, 0);
    send_vertex(0, one, -one, one);
    drain_wait();
  endtask

  task automatic test_random_settings();
    for (int p = 0; p < 8; p++) begin
      for (int r = 0; r < 4; r++) write_reg(CfgIdxW'(r), rand_row());
      write_reg(RegWidth, RowW'($urandom_range(1, 4096)));
      write_reg(RegHeight, RowW'(p == 7 ? 4096 : $urandom_range(1, 4096)));
      idle_mode = idle_mode_e'(p % 4);
      send_random(40);
      drain_wait();
    end
  endtask

  task automatic test_backpressure();
    idle_mode = IdleNone;
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk_i);
        hold_off = 1'b0;
      end
      send_random(60);
    join
    drain_wait();   // sender pauses until the pipe is empty
    send_random(20);
    drain_wait();
  endtask

  function automatic void ref_init();
    mat_rows[0] = 64'h0000_0000_0000_1000;
    mat_rows[1] = 64'h0000_0000_1000_0000;
    mat_rows[2] = 64'h0000_1000_0000_0000;
    mat_rows[3] = 64'h1000_0000_0000_0000;
    view_w = ResetWidth;
    view_h = ResetHeight;
  endfunction

  initial begin
    ref_init();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_settings();
    test_backpressure();
    if (mismatches == 0 && pending_screens.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule

FILE: files.f
rtl/vsp_pkg.sv
rtl/vertex_screen_projection_unit.sv
tb/sv/tb.sv
